// File: rtl/core/key_debounce_event_generator_macros.svh
// Assertion macros shared by the key debounce event generator RTL.
`ifndef KEY_DEBOUNCE_EVENT_GENERATOR_MACROS_SVH
`define KEY_DEBOUNCE_EVENT_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KDEG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KDEG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/kdeg_pkg.sv
// Package with shared constants of the key debounce event generator.
`timescale 1ns / 1ps
`default_nettype none
package kdeg_pkg;
    localparam int NUM_KEYS_DEF      = 10;
    localparam int HISTORY_DEPTH_DEF = 4;
    localparam int RAW_W             = 10;
    localparam int INDEX_W           = 4;
    localparam int QUEUE_DEPTH       = 2;
    localparam int S_TDATA_W         = 16;
    localparam int M_TDATA_W         = 8;
endpackage
`default_nettype wire

// File: rtl/core/kdeg_front.sv
// Front end: scan history, debounce decision and reported-state tracking.
`timescale 1ns / 1ps
`default_nettype none
module kdeg_front #(
    parameter int NUM_KEYS      = kdeg_pkg::NUM_KEYS_DEF,
    parameter int HISTORY_DEPTH = kdeg_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [kdeg_pkg::RAW_W-1:0] raw_keys,
    input  wire logic                      q_full,
    output logic                           q_push,
    output logic [2*NUM_KEYS-1:0]          q_entry   // {new state, change mask}
);
    import kdeg_pkg::*;

    localparam int SLOT_W = $clog2(HISTORY_DEPTH);

    logic [NUM_KEYS-1:0] hist_reg [HISTORY_DEPTH];
    logic [SLOT_W-1:0]   slot_reg;
    logic [SLOT_W-1:0]   slot_next;
    logic [NUM_KEYS-1:0] reported_reg;
    logic [NUM_KEYS-1:0] reported_next;
    logic [NUM_KEYS-1:0] scan;
    logic [NUM_KEYS-1:0] all_on;
    logic [NUM_KEYS-1:0] all_off;
    logic [NUM_KEYS-1:0] change;
    logic                accept;

    // Key lines beyond the scan width read as released.
    genvar g;
    generate
        for (g = 0; g < NUM_KEYS; g++)
        begin : g_scan
            if (g < RAW_W)
            begin : g_in
                assign scan[g] = raw_keys[g];
            end
            else
            begin : g_zero
                assign scan[g] = 1'b0;
            end
        end
    endgenerate

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        all_on  = '1;
        all_off = '1;
        for (int s = 0; s < HISTORY_DEPTH; s++)
        begin
            // The slot being written this cycle counts with the new scan, not its old value.
            if (slot_reg == SLOT_W'(s))
            begin
                all_on  = all_on & scan;
                all_off = all_off & ~scan;
            end
            else
            begin
                all_on  = all_on & hist_reg[s];
                all_off = all_off & ~hist_reg[s];
            end
        end
        change        = (all_on & ~reported_reg) | (all_off & reported_reg);
        reported_next = reported_reg ^ change;
        slot_next     = (slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
    end

    assign q_push  = accept && (change != '0);
    assign q_entry = {reported_next, change};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < HISTORY_DEPTH; s++)
            begin
                hist_reg[s] <= '0;
            end
            slot_reg     <= '0;
            reported_reg <= '0;
        end
        else if (accept)
        begin
            hist_reg[slot_reg] <= scan;
            slot_reg           <= slot_next;
            reported_reg       <= reported_next;
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/kdeg_queue.sv
// Small register queue between the front end and the event serializer.
`timescale 1ns / 1ps
`default_nettype none
module kdeg_queue #(
    parameter int WIDTH = 2 * kdeg_pkg::NUM_KEYS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  valid,
    output logic [WIDTH-1:0]      pop_data
);
    import kdeg_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/kdeg_back.sv
// Back end: turns a change mask into one event per changed key, lowest first.
`timescale 1ns / 1ps
`default_nettype none
module kdeg_back #(
    parameter int NUM_KEYS = kdeg_pkg::NUM_KEYS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_valid,
    input  wire logic [2*NUM_KEYS-1:0]        q_entry,
    output logic                              q_pop,
    output logic                              ev_valid,
    input  wire logic                         ev_ready,
    output logic [kdeg_pkg::INDEX_W-1:0]      ev_index,
    output logic                              ev_pressed,
    output logic                              ev_last
);
    import kdeg_pkg::*;

    logic                busy_reg;
    logic [NUM_KEYS-1:0] mask_reg;
    logic [NUM_KEYS-1:0] state_reg;
    logic                out_valid_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic                out_pressed_reg;
    logic                out_last_reg;
    logic [NUM_KEYS-1:0] low;
    logic [NUM_KEYS-1:0] remaining;
    logic [INDEX_W-1:0]  low_index;
    logic                out_free;
    logic                emit;

    always_comb
    begin
        low       = mask_reg & (~mask_reg + 1'b1);
        remaining = mask_reg & ~low;
        low_index = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            low_index = low_index | ({INDEX_W{low[k]}} & INDEX_W'(k));
        end
    end

    assign out_free = !out_valid_reg || ev_ready;
    assign emit     = busy_reg && out_free;
    // Next entry loads in the same cycle the last event of the current one goes out.
    assign q_pop    = q_valid && (!busy_reg || (emit && (remaining == '0)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                busy_reg <= 1'b1;
            end
            else if (emit)
            begin
                busy_reg <= (remaining != '0);
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (ev_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            mask_reg  <= q_entry[NUM_KEYS-1:0];
            state_reg <= q_entry[2*NUM_KEYS-1:NUM_KEYS];
        end
        else if (emit)
        begin
            mask_reg <= remaining;
        end
        if (emit)
        begin
            out_index_reg   <= low_index;
            out_pressed_reg <= |(low & state_reg);
            out_last_reg    <= (remaining == '0);
        end
    end

    assign ev_valid   = out_valid_reg;
    assign ev_index   = out_index_reg;
    assign ev_pressed = out_pressed_reg;
    assign ev_last    = out_last_reg;
endmodule
`default_nettype wire

// File: rtl/core/key_debounce_event_generator.sv
// Key debounce event generator: scans in, key press and release events out.
//
// Slave stream carries one scan of the key lines per item (bit i set = key i down).
// Master stream carries one event per item: key index and new state, tlast on the
// final event caused by a scan. A scan that changes no debounced state gives no event.
// A key settles pressed after HISTORY_DEPTH consecutive pressed scans, released after
// HISTORY_DEPTH consecutive released scans.
// A scan's first event passes the queue, the serializer mask and the output register.
// Throughput: a scan is taken every cycle while the two-entry event queue has room;
// events leave one per cycle while the receiver is ready, so a scan with k changes
// holds the serializer for k events, and the serializer loop sets the sustained rate.
// When the receiver stalls, the held event stays put, the queue fills, and tready on
// the scan side drops once both queue entries are taken.
// Reset clears the scan history, slot pointer, reported key states and the queue;
// the block takes scans in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none
module key_debounce_event_generator #(
    parameter int NUM_KEYS      = kdeg_pkg::NUM_KEYS_DEF,
    parameter int HISTORY_DEPTH = kdeg_pkg::HISTORY_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [kdeg_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [9:0] raw_keys
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [kdeg_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // [3:0] key_index, [4] pressed
    output logic                                m_axis_tlast   // last_event
);
    import kdeg_pkg::*;

    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_valid;
    logic [2*NUM_KEYS-1:0] q_in;
    logic [2*NUM_KEYS-1:0] q_out;
    logic [INDEX_W-1:0]    ev_index;
    logic                  ev_pressed;
    logic                  index_ok;
    logic                  ev_stall;

    kdeg_front #(
        .NUM_KEYS      (NUM_KEYS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .raw_keys (s_axis_tdata[RAW_W-1:0]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    kdeg_queue #(
        .WIDTH (2 * NUM_KEYS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    kdeg_back #(
        .NUM_KEYS (NUM_KEYS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_entry    (q_out),
        .q_pop      (q_pop),
        .ev_valid   (m_axis_tvalid),
        .ev_ready   (m_axis_tready),
        .ev_index   (ev_index),
        .ev_pressed (ev_pressed),
        .ev_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {{(M_TDATA_W - INDEX_W - 1){1'b0}}, ev_pressed, ev_index};

    assign index_ok = (NUM_KEYS > 16) || (int'(ev_index) < NUM_KEYS);
    assign ev_stall = m_axis_tvalid && !m_axis_tready;

`include "key_debounce_event_generator_macros.svh"

    `KDEG_ASSERT_NOW(a_no_push_when_full, clk, rst_n, q_push, !q_full, "push into full queue")
    `KDEG_ASSERT_NOW(a_no_pop_when_empty, clk, rst_n, q_pop, q_valid, "pop from empty queue")
    `KDEG_ASSERT_NOW(a_index_in_range, clk, rst_n, m_axis_tvalid, index_ok, "bad key index")
    `KDEG_ASSERT_NEXT(a_ev_hold, clk, rst_n, ev_stall, m_axis_tvalid, "stalled event dropped")
endmodule
`default_nettype wire

// File: tb/sv/tb_key_debounce_event_generator.sv
// Self-checking testbench for the key debounce event generator.
`timescale 1ns / 1ps
module tb_key_debounce_event_generator;
    import kdeg_pkg::*;

    localparam int NK = NUM_KEYS_DEF;
    localparam int HD = HISTORY_DEPTH_DEF;
    localparam int SCAN_TARGET = 460;

    typedef struct {
        bit               drain;  // hold off until every expected event is out
        logic [RAW_W-1:0] keys;
    } scan_item_t;

    typedef struct {
        logic [INDEX_W-1:0] index;
        logic               pressed;
        logic               last;
    } key_evt_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;   // [9:0] raw_keys
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // [3:0] key_index, [4] pressed
    logic                 m_axis_tlast;        // last_event

    scan_item_t pending_scans[$];
    key_evt_t   expected_events[$];
    key_evt_t   want_evt;

    // predictor state
    logic [NK-1:0] key_hist[HD];
    int            hist_slot = 0;
    logic [NK-1:0] key_state = '0;

    int mismatch_count = 0;
    int scans_accepted = 0;
    int gap_left = 0;
    int stall_left = 0;
    bit no_idle = 1'b0;
    bit scan_taken = 1'b0;

    key_debounce_event_generator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("%0t ns  MISMATCH  %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Write the scan into the history, then emit an event per key whose
    // settled state differs from the reported one, lowest key first.
    function automatic void debounce_scan(input logic [RAW_W-1:0] raw);
        logic [NK-1:0] all_down;
        logic [NK-1:0] all_up;
        key_evt_t      found[$];
        key_evt_t      e;
        key_hist[hist_slot] = raw[NK-1:0];
        hist_slot = (hist_slot + 1) % HD;
        all_down = '1;
        all_up = '1;
        for (int d = 0; d < HD; d++)
        begin
            all_down &= key_hist[d];
            all_up &= ~key_hist[d];
        end
        for (int k = 0; k < NK; k++)
        begin
            e.index = INDEX_W'(k);
            e.last = 1'b0;
            if (all_down[k] && !key_state[k])
            begin
                key_state[k] = 1'b1;
                e.pressed = 1'b1;
                found.push_back(e);
            end
            else if (all_up[k] && key_state[k])
            begin
                key_state[k] = 1'b0;
                e.pressed = 1'b0;
                found.push_back(e);
            end
        end
        if (found.size() > 0)
            found[found.size() - 1].last = 1'b1;
        foreach (found[n])
            expected_events.push_back(found[n]);
    endfunction

    function automatic void push_scan(input logic [RAW_W-1:0] keys, input int reps);
        scan_item_t it;
        it.drain = 1'b0;
        it.keys = keys;
        repeat (reps)
            pending_scans.push_back(it);
    endfunction

    function automatic void push_drain();
        scan_item_t it;
        it.drain = 1'b1;
        it.keys = '0;
        pending_scans.push_back(it);
    endfunction

    // scan driver
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (s_axis_tvalid && !scan_taken)
        begin
            // item still waiting for tready
        end
        else if (gap_left > 0)
        begin
            gap_left <= gap_left - 1;
            s_axis_tvalid <= 1'b0;
        end
        else if (pending_scans.size() == 0)
            s_axis_tvalid <= 1'b0;
        else if (pending_scans[0].drain)
        begin
            s_axis_tvalid <= 1'b0;
            if (expected_events.size() == 0)
                void'(pending_scans.pop_front());
        end
        else
        begin
            s_axis_tdata <= {{(S_TDATA_W - RAW_W){1'b0}}, pending_scans[0].keys};
            s_axis_tvalid <= 1'b1;
            void'(pending_scans.pop_front());
            gap_left <= pick_gap();
        end
    end

    // event receiver backpressure
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!no_idle && $urandom_range(0, 99) < 25)
                stall_left <= pick_gap();
        end
    end

    // monitor: predict on accepted scans, check accepted events
    always @(posedge clk)
    begin
        if (!rst_n)
            scan_taken = 1'b0;
        else
        begin
            scan_taken = s_axis_tvalid && s_axis_tready;
            if (scan_taken)
            begin
                debounce_scan(s_axis_tdata[RAW_W-1:0]);
                scans_accepted++;
                if (scans_accepted % 50 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_events.size() == 0)
                    report_mismatch($sformatf("unexpected event: key %0d pressed %0d last %0d",
                        m_axis_tdata[INDEX_W-1:0], m_axis_tdata[INDEX_W], m_axis_tlast));
                else
                begin
                    want_evt = expected_events.pop_front();
                    if (m_axis_tdata[INDEX_W-1:0] !== want_evt.index)
                        report_mismatch($sformatf("key_index got %0d want %0d",
                            m_axis_tdata[INDEX_W-1:0], want_evt.index));
                    if (m_axis_tdata[INDEX_W] !== want_evt.pressed)
                        report_mismatch($sformatf("pressed got %0b want %0b (key %0d)",
                            m_axis_tdata[INDEX_W], want_evt.pressed, want_evt.index));
                    if (m_axis_tlast !== want_evt.last)
                        report_mismatch($sformatf("last_event got %0b want %0b (key %0d)",
                            m_axis_tlast, want_evt.last, want_evt.index));
                end
            end
        end
    end

    initial
    begin
        int               queued;
        int               hold;
        logic [RAW_W-1:0] cur;
        logic [RAW_W-1:0] target;

        foreach (key_hist[d])
            key_hist[d] = '0;

        // directed part
        push_scan(10'h000, 1);            // nothing changes
        push_scan(10'h3FF, 4);            // every key settles pressed on the 4th scan
        push_scan(10'h155, 1);            // mixed history, keys unsettled
        push_scan(10'h2AA, 1);
        push_scan(10'h000, 3);
        push_scan(10'h000, 1);            // all released in one scan
        push_drain();
        push_scan(10'h001, 4);
        push_scan(10'h200, 4);            // key 0 release and key 9 press together
        push_scan(10'h000, 4);
        push_drain();
        queued = 23;

        // random part: mostly settled patterns with bounce, some pure noise
        cur = '0;
        while (queued < SCAN_TARGET)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                if ($urandom_range(0, 1) == 0)
                    target = RAW_W'($urandom_range(0, 1023));
                else
                    target = cur ^ (RAW_W'(1) << $urandom_range(0, RAW_W - 1))
                                 ^ (RAW_W'($urandom_range(0, 1)) << $urandom_range(0, RAW_W - 1));
                if ($urandom_range(0, 2) == 0)
                begin
                    hold = $urandom_range(1, 3);
                    repeat (hold)
                        push_scan(target ^ RAW_W'($urandom_range(0, 1023)), 1);
                    queued += hold;
                end
                hold = $urandom_range(HD, HD + 3);
                push_scan(target, hold);
                queued += hold;
                cur = target;
            end
            else
            begin
                hold = $urandom_range(1, 3);
                repeat (hold)
                    push_scan(RAW_W'($urandom_range(0, 1023)), 1);
                queued += hold;
            end
            if ($urandom_range(0, 29) == 0)
                push_drain();
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_scans.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (expected_events.size() != 0)
            report_mismatch($sformatf("%0d events never arrived", expected_events.size()));

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #(64'd15_000_000);
        $display("timeout");
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/kdeg_pkg.sv
rtl/core/kdeg_front.sv
rtl/core/kdeg_queue.sv
rtl/core/kdeg_back.sv
rtl/core/key_debounce_event_generator.sv
tb/sv/tb_key_debounce_event_generator.sv
